// ----- hw/rtl/bfc_pkg.sv -----
// Package for the box frustum cull block: payload types, matrix types,
// register indexes and result codes. Depends on nothing.
package bfc_pkg;

  localparam int NumRegs  = 8;
  localparam int RegW     = 64;
  localparam int IdxW     = 4;
  localparam int OneShift = 16;

  typedef logic signed [31:0] q16_t;
  typedef q16_t [3:0][3:0] mat_t;            // [row][col]
  typedef logic [RegW-1:0] reg_word_t;

  typedef logic signed [63:0] prod_t;
  typedef prod_t [2:0][1:0][3:0] prod_arr_t; // [axis][min/max][col]
  typedef prod_t [3:0] wrow_t;               // w row scaled by 1.0

  typedef logic signed [64:0] pair_t;
  typedef pair_t [1:0][1:0][3:0] xy_arr_t;   // [ysel][xsel][col]
  typedef pair_t [1:0][3:0] zw_arr_t;        // [zsel][col]

  typedef logic signed [65:0] tsum_t;
  typedef tsum_t [7:0][3:0] corner_arr_t;    // [corner][col]

  typedef enum logic [IdxW-1:0] {
    REG_R0_C01 = 4'd0,
    REG_R0_C23 = 4'd1,
    REG_R1_C01 = 4'd2,
    REG_R1_C23 = 4'd3,
    REG_R2_C01 = 4'd4,
    REG_R2_C23 = 4'd5,
    REG_R3_C01 = 4'd6,
    REG_R3_C23 = 4'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    VIS_HIDDEN  = 2'd0,
    VIS_INSIDE  = 2'd1,
    VIS_PARTIAL = 2'd2
  } vis_t;

  localparam reg_word_t RegReset [NumRegs] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

endpackage

// ----- hw/rtl/bfc_mul_stage.sv -----
// First pipeline stage: min and max coordinate times matrix entry products,
// plus the w row scaled by 1.0. Depends on bfc_pkg.
module bfc_mul_stage (
  input  logic              clk,
  input  logic              en,
  input  bfc_pkg::q16_t     box_min_x,
  input  bfc_pkg::q16_t     box_min_y,
  input  bfc_pkg::q16_t     box_min_z,
  input  bfc_pkg::q16_t     box_max_x,
  input  bfc_pkg::q16_t     box_max_y,
  input  bfc_pkg::q16_t     box_max_z,
  input  bfc_pkg::mat_t     mat,
  output bfc_pkg::prod_arr_t prod,
  output bfc_pkg::wrow_t    wrow
);
  import bfc_pkg::*;

  q16_t coord [3][2];

  always_comb begin
    coord[0][0] = box_min_x;
    coord[0][1] = box_max_x;
    coord[1][0] = box_min_y;
    coord[1][1] = box_max_y;
    coord[2][0] = box_min_z;
    coord[2][1] = box_max_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int s = 0; s < 2; s++) begin
          for (int c = 0; c < 4; c++) begin
            prod[k][s][c] <= 64'(coord[k][s]) * 64'(mat[k][c]);
          end
        end
      end
      for (int c = 0; c < 4; c++) begin
        wrow[c] <= 64'(mat[3][c]) <<< OneShift;
      end
    end
  end

endmodule

// ----- hw/rtl/bfc_sum_stage.sv -----
// Second and third pipeline stages: partial sums of the products, then the
// clip-space coordinates of all eight corners. Depends on bfc_pkg.
module bfc_sum_stage (
  input  logic                 clk,
  input  logic                 en_pair,
  input  logic                 en_corner,
  input  bfc_pkg::prod_arr_t   prod,
  input  bfc_pkg::wrow_t       wrow,
  output bfc_pkg::corner_arr_t corner
);
  import bfc_pkg::*;

  xy_arr_t xy;
  zw_arr_t zw;

  always_ff @(posedge clk) begin
    if (en_pair) begin
      for (int c = 0; c < 4; c++) begin
        for (int jy = 0; jy < 2; jy++) begin
          for (int jx = 0; jx < 2; jx++) begin
            xy[jy][jx][c] <= 65'(prod[0][jx][c]) + 65'(prod[1][jy][c]);
          end
        end
        for (int jz = 0; jz < 2; jz++) begin
          zw[jz][c] <= 65'(prod[2][jz][c]) + 65'(wrow[c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_corner) begin
      for (int i = 0; i < 8; i++) begin
        for (int c = 0; c < 4; c++) begin
          corner[i][c] <= 66'(xy[(i >> 1) & 1][i & 1][c]) + 66'(zw[(i >> 2) & 1][c]);
        end
      end
    end
  end

endmodule

// ----- hw/rtl/bfc_code_stage.sv -----
// Last pipeline stage: per-corner outcodes, their AND and OR, and the
// visibility class, held in the output register. Depends on bfc_pkg.
module bfc_code_stage (
  input  logic                 clk,
  input  logic                 en,
  input  bfc_pkg::corner_arr_t corner,
  output logic [1:0]           visibility,
  output logic [5:0]           union_code,
  output logic [5:0]           common_code
);
  import bfc_pkg::*;

  logic [5:0] code [8];
  logic [5:0] or_all;
  logic [5:0] and_all;
  vis_t       vis;

  function automatic logic [1:0] plane_code(tsum_t a, tsum_t w);
    logic signed [66:0] s;
    logic signed [66:0] d;
    s = 67'(a) + 67'(w);
    d = 67'(a) - 67'(w);
    if (s[66]) begin
      plane_code = 2'b01;
    end else if (!d[66] && (d != '0)) begin
      plane_code = 2'b10;
    end else begin
      plane_code = 2'b00;
    end
  endfunction

  always_comb begin
    or_all  = '0;
    and_all = '1;
    for (int i = 0; i < 8; i++) begin
      code[i] = {plane_code(corner[i][2], corner[i][3]),
                 plane_code(corner[i][1], corner[i][3]),
                 plane_code(corner[i][0], corner[i][3])};
      or_all  = or_all | code[i];
      and_all = and_all & code[i];
    end
    if (and_all != '0) begin
      vis = VIS_HIDDEN;
    end else if (or_all == '0) begin
      vis = VIS_INSIDE;
    end else begin
      vis = VIS_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      visibility  <= vis;
      union_code  <= or_all;
      common_code <= and_all;
    end
  end

endmodule

// ----- hw/rtl/box_frustum_cull.sv -----
// Top level of the box frustum cull block: matrix registers, pipeline valid
// control and the three stage modules. Depends on bfc_pkg and the bfc stages.
//
// Takes axis-aligned boxes and reports whether each box's eight corners,
// transformed by the configured 4x4 Q16.16 matrix (row vectors), lie outside,
// fully inside or across the clip volume, with the OR and AND of the corner
// outcodes. Each box passes the registered stages product multiply, pair sum,
// corner sum and outcode compare into the output register. A new box is accepted
// every cycle while in_ready is high; a stage holds only while its successor
// is full and stalled. Write the matrix only while no box is in flight.
module box_frustum_cull (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [bfc_pkg::IdxW-1:0] cfg_index,
  input  bfc_pkg::reg_word_t      cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  bfc_pkg::q16_t           box_min_x,
  input  bfc_pkg::q16_t           box_min_y,
  input  bfc_pkg::q16_t           box_min_z,
  input  bfc_pkg::q16_t           box_max_x,
  input  bfc_pkg::q16_t           box_max_y,
  input  bfc_pkg::q16_t           box_max_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              visibility,
  output logic [5:0]              union_code,
  output logic [5:0]              common_code
);
  import bfc_pkg::*;

  reg_word_t   regs [NumRegs];
  mat_t        mat;
  logic [3:0]  vld;
  logic [3:0]  en;
  prod_arr_t   prod;
  wrow_t       wrow;
  corner_arr_t corner;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs[i] <= RegReset[i];
      end
    end else if (cfg_we && (cfg_index <= REG_R3_C23)) begin
      regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = regs[r*2][31:0];
      mat[r][1] = regs[r*2][63:32];
      mat[r][2] = regs[r*2+1][31:0];
      mat[r][3] = regs[r*2+1][63:32];
    end
  end

  assign en[3] = !vld[3] || out_ready;
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];

  assign in_ready  = en[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
    end
  end

  bfc_mul_stage u_mul (
    .clk       (clk),
    .en        (en[0]),
    .box_min_x (box_min_x),
    .box_min_y (box_min_y),
    .box_min_z (box_min_z),
    .box_max_x (box_max_x),
    .box_max_y (box_max_y),
    .box_max_z (box_max_z),
    .mat       (mat),
    .prod      (prod),
    .wrow      (wrow)
  );

  bfc_sum_stage u_sum (
    .clk       (clk),
    .en_pair   (en[1]),
    .en_corner (en[2]),
    .prod      (prod),
    .wrow      (wrow),
    .corner    (corner)
  );

  bfc_code_stage u_code (
    .clk         (clk),
    .en          (en[3]),
    .corner      (corner),
    .visibility  (visibility),
    .union_code  (union_code),
    .common_code (common_code)
  );

`ifndef SYNTH
  a_common_in_union: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((common_code & ~union_code) == 6'd0))
    else $error("common code not contained in union code");

  a_hidden_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((visibility == VIS_HIDDEN) == (common_code != 6'd0)))
    else $error("hidden class disagrees with common code");

  a_inside_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (visibility == VIS_INSIDE)) |-> (union_code == 6'd0))
    else $error("inside class with nonzero union code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(union_code)))
    else $error("stalled result changed");
`endif

endmodule

// ----- verif/tb_box_frustum_cull.sv -----
// Testbench for box_frustum_cull: drives boxes through the valid/ready port,
// predicts the cull class and outcodes per box and checks each result in order.
// Depends on bfc_pkg and the box_frustum_cull RTL.
`timescale 1ns / 100ps

class cull_scoreboard;
  logic [13:0] pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  function void note_box(logic [13:0] cull);
    pending.push_back(cull);
  endfunction

  function void check_cull(logic [1:0] vis, logic [5:0] uni, logic [5:0] com);
    logic [13:0] e;
    if (pending.size() == 0) begin
      $error("unexpected result vis=%0d union=%0h common=%0h", vis, uni, com);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (vis !== e[13:12]) begin
      $error("visibility expected %0d actual %0d", e[13:12], vis);
      errors++;
    end
    if (uni !== e[11:6]) begin
      $error("union_code expected %0h actual %0h", e[11:6], uni);
      errors++;
    end
    if (com !== e[5:0]) begin
      $error("common_code expected %0h actual %0h", e[5:0], com);
      errors++;
    end
  endfunction
endclass

module tb_box_frustum_cull;
  import bfc_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [IdxW-1:0] cfg_index = '0;
  reg_word_t cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  q16_t box_min_x = 0, box_min_y = 0, box_min_z = 0;
  q16_t box_max_x = 0, box_max_y = 0, box_max_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] visibility;
  logic [5:0] union_code, common_code;

  reg_word_t matrix_regs [NumRegs];
  cull_scoreboard sb;
  bit calm;
  int hold_off;
  longint cycles;

  box_frustum_cull dut (.*);

  always #1 clk = ~clk;

  function automatic logic signed [31:0] entry(int r, int c);
    reg_word_t w;
    w = matrix_regs[r * 2 + c / 2];
    return (c % 2) ? w[63:32] : w[31:0];
  endfunction

  function automatic logic [1:0] plane(logic signed [127:0] a, logic signed [127:0] w);
    if (a + w < 0) return 2'b01;
    if (a - w > 0) return 2'b10;
    return 2'b00;
  endfunction

  function automatic logic [13:0] cull_box(q16_t lo[3], q16_t hi[3]);
    logic signed [127:0] v[4], t[4];
    logic [5:0] orc, andc, code;
    logic [1:0] vis;
    orc = 0;
    andc = 6'h3f;
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 3; k++) v[k] = ((i >> k) & 1) ? hi[k] : lo[k];
      v[3] = 65536;
      for (int c = 0; c < 4; c++) begin
        t[c] = 0;
        for (int r = 0; r < 4; r++) t[c] += v[r] * 128'(signed'(entry(r, c)));
      end
      code = {plane(t[2], t[3]), plane(t[1], t[3]), plane(t[0], t[3])};
      andc &= code;
      orc |= code;
    end
    if (andc != 0) vis = VIS_HIDDEN;
    else if (orc == 0) vis = VIS_INSIDE;
    else vis = VIS_PARTIAL;
    return {vis, orc, andc};
  endfunction

  task automatic write_reg(reg_idx_t idx, reg_word_t val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (int'(idx) < NumRegs) matrix_regs[idx] = val;
    @(posedge clk);
  endtask

  task automatic send_box(q16_t a0, q16_t a1, q16_t a2, q16_t b0, q16_t b1, q16_t b2);
    q16_t lo[3], hi[3];
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 0;
      @(posedge clk);
    end
    lo = '{a0, a1, a2};
    hi = '{b0, b1, b2};
    in_valid <= 1;
    {box_min_x, box_min_y, box_min_z} <= {a0, a1, a2};
    {box_max_x, box_max_y, box_max_z} <= {b0, b1, b2};
    do @(posedge clk); while (!in_ready);
    sb.note_box(cull_box(lo, hi));
  endtask

  function automatic q16_t rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
      default: return $signed($urandom_range(0, 32'h4000000)) - 32'sh2000000;
    endcase
  endfunction

  function automatic reg_word_t rand_word(int mode);
    logic [31:0] a, b;
    case (mode)
      0: begin a = $urandom; b = $urandom; end
      default: begin
        a = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
        b = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
      end
    endcase
    return {b, a};
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("box_frustum_cull test failed");
      $finish;
    end
    if (!rst && out_valid && out_ready) sb.check_cull(visibility, union_code, common_code);
    if (hold_off > 0) begin
      hold_off--;
      out_ready <= 0;
    end else out_ready <= calm || ($urandom_range(99) >= 20);
  end

  initial begin
    q16_t mn, mx;
    int m;
    sb = new();
    cycles = 0;
    calm = 0;
    hold_off = 0;
    for (int i = 0; i < NumRegs; i++) matrix_regs[i] = RegReset[i];
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    mn = 32'sh80000000;
    mx = 32'sh7fffffff;
    send_box(-32'sh8000, -32'sh8000, -32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000);
    send_box(-32'sh20000, -32'sh8000, -32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000);
    send_box(32'sh20000, 32'sh20000, 32'sh20000, 32'sh30000, 32'sh30000, 32'sh30000);
    send_box(-32'sh30000, -32'sh30000, -32'sh30000, -32'sh20000, -32'sh20000, -32'sh20000);
    send_box(32'sh8000, 32'sh8000, 32'sh8000, -32'sh8000, -32'sh8000, -32'sh8000);
    send_box(mn, mn, mn, mx, mx, mx);
    send_box(mx, mx, mx, mn, mn, mn);
    send_box(mn, mn, mn, mn, mn, mn);
    send_box(mx, mx, mx, mx, mx, mx);
    send_box(0, 0, 0, 0, 0, 0);
    send_box(32'sh10000, 0, 0, 32'sh10000, 0, 0);
    send_box(-1, -1, -1, -1, -1, -1);
    drain();

    // negative w row: left wins over right
    for (int i = 0; i < NumRegs; i++) write_reg(reg_idx_t'(i), RegReset[i]);
    write_reg(REG_R3_C23, {32'hffff0000, 32'h0});
    write_reg(REG_R0_C01, {32'h7fffffff, 32'h80000000});
    write_reg(REG_R1_C23, {32'h80000000, 32'h7fffffff});
    send_box(-32'sh8000, -32'sh8000, -32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000);
    send_box(mn, mn, mn, mx, mx, mx);
    send_box(0, 0, 0, 0, 0, 0);
    drain();
    write_reg(reg_idx_t'(NumRegs), '1);
    write_reg(REG_R2_C01, '1);
    send_box(mn, 0, mx, mx, 0, mn);
    drain();
    write_reg(REG_R2_C01, '0);

    for (int ph = 0; ph < 10; ph++) begin
      m = $urandom_range(0, 2);
      for (int i = 0; i < NumRegs; i++) begin
        if (ph == 0) write_reg(reg_idx_t'(i), RegReset[i]);
        else if (ph == 1) write_reg(reg_idx_t'(i), '1);
        else if (ph == 2) write_reg(reg_idx_t'(i), {2{32'h7fffffff}});
        else if (ph == 3) write_reg(reg_idx_t'(i), {2{32'h80000000}});
        else write_reg(reg_idx_t'(i), rand_word(ph % 3 == 0 ? 0 : 1));
      end
      if (ph == 0) write_reg(REG_R3_C01, {32'h0, 32'h8000});
      calm = (ph == 5);
      if (ph == 6) hold_off = 300;
      for (int n = 0; n < 150; n++) begin
        mn = rand_coord((m + n) % 3);
        send_box(rand_coord(n % 3), rand_coord(m), mn,
                 rand_coord((n + 1) % 3), rand_coord(m), mn + rand_coord(1));
      end
      calm = 0;
      drain();
    end

    if (sb.errors == 0) $display("box_frustum_cull test passed");
    else $display("box_frustum_cull test failed");
    $finish;
  end
endmodule
